// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL; empty bodies for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition holds at every clock edge out of reset.
`define HEGS_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");
// Antecedent implies consequent in the next cycle.
`define HEGS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define HEGS_ASSERT(lbl, cond)
`define HEGS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/hegs_pkg.sv -----
// Package: widths, constants and tables of the heading error gain scheduler.
package hegs_pkg;

  localparam int unsigned CordicStepsDefault = 16;
  localparam int unsigned AtanLen            = 24;

  // Request kinds carried on tuser
  localparam logic ReqHeading = 1'b0;
  localparam logic ReqPoint   = 1'b1;

  localparam int unsigned XW   = 44;  // CORDIC x/y width (Q16 of 1/256 inch)
  localparam int unsigned ZW   = 32;  // angle accumulator, degrees * 2^22
  localparam int unsigned AccW = 56;  // Horner accumulator, Q44
  localparam int unsigned PW   = 72;  // Horner product

  localparam logic signed [28:0] RadToDeg64 = 29'sd240315917;
  localparam logic signed [ZW-1:0] Deg90 = 32'sd377487360;  // 90 * 2^22

  // Wrap constants (1/64 degree)
  localparam logic signed [15:0] FullTurn = 16'sd23040;
  localparam logic signed [15:0] HalfTurn = 16'sd11520;
  localparam logic [14:0] OffsetMod = 15'd4096;   // 2^24 mod 23040
  localparam logic [16:0] Recip45 = 17'd93207;    // ceil(2^22 / 45)

  localparam logic signed [AccW-1:0] GainMax = 56'sd16777215;
  localparam logic signed [AccW-1:0] GainMin = -56'sd16777216;

  // atan(2^-i) in degrees * 2^22
  function automatic logic signed [ZW-1:0] atan_deg22(input int unsigned i);
    logic signed [ZW-1:0] r;
    case (i)
      0: r = 32'sd188743680;
      1: r = 32'sd111421900;
      2: r = 32'sd58872272;
      3: r = 32'sd29884485;
      4: r = 32'sd15000234;
      5: r = 32'sd7507429;
      6: r = 32'sd3754631;
      7: r = 32'sd1877430;
      8: r = 32'sd938729;
      9: r = 32'sd469366;
      10: r = 32'sd234683;
      11: r = 32'sd117342;
      12: r = 32'sd58671;
      13: r = 32'sd29335;
      14: r = 32'sd14668;
      15: r = 32'sd7334;
      16: r = 32'sd3667;
      17: r = 32'sd1833;
      18: r = 32'sd917;
      19: r = 32'sd458;
      20: r = 32'sd229;
      21: r = 32'sd115;
      22: r = 32'sd57;
      23: r = 32'sd29;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Gain polynomial coefficients in Q44, highest power first
  function automatic logic signed [AccW-1:0] kp_coef(input int unsigned k);
    logic signed [AccW-1:0] r;
    case (k)
      0: r = -56'sd731809;
      1: r = 56'sd295733444;
      2: r = -56'sd39117633040;
      3: r = 56'sd1747576095700;
      4: r = 56'sd5355941041500;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/heading_error_gain_schedule_top.sv -----
// Top level: pipelined turn-angle wrap and gain schedule.
//
//  channel  | dir | handshake               | tdata / tuser
//  s_axis   | in  | s_axis_tvalid/tready    | request word, req_type on tuser
//  m_axis   | out | m_axis_tvalid/tready    | turn_angle, turn_gain
//
// One word per cycle while the output is not stalled; the pipe is built from one
// CORDIC step per stage plus the wrap and the eight Horner stages.
// Reset clears only the valid bits; payload registers are not reset.
// A stall at the output freezes the whole pipeline; nothing is lost or
// repeated. Input is taken whenever the output register is empty or drains.

`include "assert_macros.svh"

module heading_error_gain_schedule_top #(
  parameter int unsigned CORDIC_STEPS = hegs_pkg::CordicStepsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [16:0] target_heading, [40:17] target_x, [64:41] target_y,
  // [88:65] pose_x, [112:89] pose_y, [136:113] pose_theta, [143:137] zero
  input  logic [143:0] s_axis_tdata_i,
  // [0] req_type
  input  logic         s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [14:0] turn_angle, [39:15] turn_gain
  output logic [39:0]  m_axis_tdata_o
);

  localparam int unsigned XW   = hegs_pkg::XW;
  localparam int unsigned ZW   = hegs_pkg::ZW;
  localparam int unsigned AccW = hegs_pkg::AccW;
  localparam int unsigned PW   = hegs_pkg::PW;
  localparam int unsigned NS   = (CORDIC_STEPS > hegs_pkg::AtanLen) ?
                                 hegs_pkg::AtanLen : CORDIC_STEPS;
  localparam int unsigned NV   = NS + 14;

  logic          adv;
  logic [NV-1:0] vld_q, vld_d;

  // whole pipe advances unless the output word is held
  assign adv             = !vld_q[NV-1] || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign vld_d           = {vld_q[NV-2:0], s_axis_tvalid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  // input field split
  logic signed [16:0] in_th;
  logic signed [23:0] in_tx, in_ty, in_px, in_py, in_pt;
  assign in_th = s_axis_tdata_i[16:0];
  assign in_tx = s_axis_tdata_i[40:17];
  assign in_ty = s_axis_tdata_i[64:41];
  assign in_px = s_axis_tdata_i[88:65];
  assign in_py = s_axis_tdata_i[112:89];
  assign in_pt = s_axis_tdata_i[136:113];

  // stage A: deltas and heading scale product
  logic               a_typ_q;
  logic signed [24:0] a_dx_q, a_dy_q;
  logic signed [45:0] a_hp_q;
  logic signed [23:0] a_th_q;
  logic signed [45:0] hp_w;
  assign hp_w = in_th * hegs_pkg::RadToDeg64;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_typ_q <= s_axis_tuser_i;
      a_dx_q  <= $signed({in_tx[23], in_tx}) - $signed({in_px[23], in_px});
      a_dy_q  <= $signed({in_ty[23], in_ty}) - $signed({in_py[23], in_py});
      a_hp_q  <= hp_w;
      a_th_q  <= in_pt;
    end
  end

  // CORDIC pipeline; index 0 is the quadrant pre-rotation
  logic signed [XW-1:0] cx_q [0:NS];
  logic signed [XW-1:0] cy_q [0:NS];
  logic signed [ZW-1:0] cz_q [0:NS];
  logic                 ct_q [0:NS];
  logic                 c0_q [0:NS];
  logic signed [16:0]   ch_q [0:NS];
  logic signed [23:0]   cth_q [0:NS];

  logic signed [XW-1:0] px_w, py_w;
  logic signed [45:0]   hr_w;
  assign px_w = {{(XW-41){a_dx_q[24]}}, a_dx_q, 16'h0};
  assign py_w = {{(XW-41){a_dy_q[24]}}, a_dy_q, 16'h0};
  assign hr_w = (a_hp_q + 46'sd268435456) >>> 29;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (px_w[XW-1]) begin
        if (!py_w[XW-1]) begin
          cx_q[0] <= py_w;
          cy_q[0] <= -px_w;
          cz_q[0] <= hegs_pkg::Deg90;
        end else begin
          cx_q[0] <= -py_w;
          cy_q[0] <= px_w;
          cz_q[0] <= -hegs_pkg::Deg90;
        end
      end else begin
        cx_q[0] <= px_w;
        cy_q[0] <= py_w;
        cz_q[0] <= '0;
      end
      ct_q[0]  <= a_typ_q;
      c0_q[0]  <= (a_dx_q == '0) && (a_dy_q == '0);
      ch_q[0]  <= hr_w[16:0];
      cth_q[0] <= a_th_q;
    end
  end

  // one vectoring step per stage
  for (genvar i = 0; i < NS; i++) begin : g_cordic
    logic signed [XW-1:0] xs, ys;
    assign xs = cx_q[i] >>> i;
    assign ys = cy_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (!cy_q[i][XW-1]) begin
          cx_q[i+1] <= cx_q[i] + ys;
          cy_q[i+1] <= cy_q[i] - xs;
          cz_q[i+1] <= cz_q[i] + hegs_pkg::atan_deg22(i);
        end else begin
          cx_q[i+1] <= cx_q[i] - ys;
          cy_q[i+1] <= cy_q[i] + xs;
          cz_q[i+1] <= cz_q[i] - hegs_pkg::atan_deg22(i);
        end
        ct_q[i+1]  <= ct_q[i];
        c0_q[i+1]  <= c0_q[i];
        ch_q[i+1]  <= ch_q[i];
        cth_q[i+1] <= cth_q[i];
      end
    end
  end

  // stage D: pick bearing, subtract pose heading
  logic signed [ZW-1:0] zr_w;
  logic signed [16:0]   ang_w;
  logic signed [24:0]   d_d, d_q;
  assign zr_w = (cz_q[NS] + 32'sd32768) >>> 16;

  always_comb begin
    if (ct_q[NS] == hegs_pkg::ReqPoint) begin
      ang_w = c0_q[NS] ? '0 : zr_w[16:0];
    end else begin
      ang_w = ch_q[NS];
    end
    d_d = $signed({{8{ang_w[16]}}, ang_w}) - $signed({cth_q[NS][23], cth_q[NS]});
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_q <= d_d;
    end
  end

  // stage W1: quotient of the biased difference by 23040 via reciprocal
  logic [24:0] u_w;
  logic [32:0] qp_w;
  logic [24:0] w_u_q;
  logic [10:0] w_qt_q;
  logic        w_neg_q;
  assign u_w  = d_q + 25'h1000000;
  assign qp_w = {17'h0, u_w[24:9]} * {16'h0, hegs_pkg::Recip45};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      w_u_q   <= u_w;
      w_qt_q  <= qp_w[32:22];
      w_neg_q <= d_q[24];
    end
  end

  // stage W2: remainder and wrap into [-180, 180]; 180 becomes -180 if the difference was negative
  logic [16:0]        r_w;
  logic [14:0]        um_w;
  logic signed [15:0] m_w;
  logic signed [14:0] t0_q;
  assign r_w  = {1'b0, w_u_q[24:9]} - {6'h0, w_qt_q} * 17'd45;
  assign um_w = {r_w[5:0], w_u_q[8:0]};

  always_comb begin
    if (um_w >= hegs_pkg::OffsetMod) begin
      m_w = $signed({1'b0, um_w - hegs_pkg::OffsetMod});
    end else begin
      m_w = $signed({1'b0, um_w}) + hegs_pkg::FullTurn - 16'sd4096;
    end
    if (m_w > hegs_pkg::HalfTurn) begin
      m_w = m_w - hegs_pkg::FullTurn;
    end
    if ((m_w == hegs_pkg::HalfTurn) && w_neg_q) begin
      m_w = -hegs_pkg::HalfTurn;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t0_q <= m_w[14:0];
    end
  end

  // Horner: multiply stage then round-and-add stage per coefficient
  logic signed [14:0]   ht_q [0:7];
  logic signed [PW-1:0] hp_q [0:3];
  logic signed [AccW-1:0] ha_q [0:3];

  for (genvar k = 0; k < 4; k++) begin : g_horner
    logic signed [AccW-1:0] acc_in;
    logic signed [14:0]     t_in;
    logic signed [PW-1:0]   prod, rnd;
    if (k == 0) begin : g_first
      assign acc_in = hegs_pkg::kp_coef(0);
      assign t_in   = t0_q;
    end else begin : g_next
      assign acc_in = ha_q[k-1];
      assign t_in   = ht_q[2*k-1];
    end
    assign prod = acc_in * t_in;
    assign rnd  = (hp_q[k] + 72'sd32) >>> 6;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        hp_q[k]     <= prod;
        ht_q[2*k]   <= t_in;
        ha_q[k]     <= rnd[AccW-1:0] + hegs_pkg::kp_coef(k + 1);
        ht_q[2*k+1] <= ht_q[2*k];
      end
    end
  end

  // output register: Q16 rounding and saturation
  logic signed [AccW-1:0] g_w;
  logic signed [24:0]     gs_w;
  logic signed [14:0]     o_turn_q;
  logic signed [24:0]     o_gain_q;
  assign g_w = (ha_q[3] + 56'sd134217728) >>> 28;

  always_comb begin
    if (g_w > hegs_pkg::GainMax) begin
      gs_w = hegs_pkg::GainMax[24:0];
    end else if (g_w < hegs_pkg::GainMin) begin
      gs_w = hegs_pkg::GainMin[24:0];
    end else begin
      gs_w = g_w[24:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_turn_q <= ht_q[7];
      o_gain_q <= gs_w;
    end
  end

  assign m_axis_tvalid_o = vld_q[NV-1];
  assign m_axis_tdata_o  = {o_gain_q, o_turn_q};

  // checks
  `HEGS_ASSERT(a_turn_range, !m_axis_tvalid_o || ((o_turn_q <= 15'sd11520) && (o_turn_q >= -15'sd11520)))
  `HEGS_ASSERT(a_ready_rule, s_axis_tready_o == (!vld_q[NV-1] || m_axis_tready_i))
  `HEGS_ASSERT_NEXT(a_stall_hold, !adv, $stable(vld_q))
  `HEGS_ASSERT(a_wrap_range, !vld_q[NV-10] || ((t0_q <= 15'sd11520) && (t0_q >= -15'sd11520)))

endmodule
